[src/smps_pkg.sv]
// smps_pkg: shared types, constants and score helpers for the Sankoff min-plus step.
// Depends on nothing; every other file in src uses it through scoped names.
package smps_pkg;

    localparam int MAX_ST     = 4;   // state slots on the ports and in the cost registers
    localparam int NUM_STATES = 4;   // states in use, 2..4
    localparam int SCORE_BITS = 16;  // internal score width, 8..32
    localparam int FIELD_BITS = 16;  // port width of every score field
    localparam int COST_BITS  = 16;  // width of one cost entry inside a column
    localparam int COL_BITS   = MAX_ST * COST_BITS;
    localparam int CFG_IDX_BITS = 8;

    typedef logic [SCORE_BITS-1:0]   t_score;
    typedef logic [FIELD_BITS-1:0]   t_field;
    typedef logic [COL_BITS-1:0]     t_cost_col;
    typedef logic [CFG_IDX_BITS-1:0] t_cfg_idx;
    typedef logic [NUM_STATES-1:0][SCORE_BITS-1:0] t_score_vec;

    // Register map.
    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_COST_COL_0 = 8'd0,
        REG_COST_COL_1 = 8'd1,
        REG_COST_COL_2 = 8'd2,
        REG_COST_COL_3 = 8'd3
    } t_cfg_reg;

    // Reset costs: 0 on the diagonal, 1 elsewhere.
    localparam t_cost_col COST_RESET [MAX_ST] = '{
        64'h0001_0001_0001_0000,
        64'h0001_0001_0000_0001,
        64'h0001_0000_0001_0001,
        64'h0000_0001_0001_0001
    };

    // Data handed from one cell to the next.
    typedef struct packed {
        t_score_vec child;    // remaining child scores, next one at slot 0
        t_score_vec partial;  // parent partial scores, passed along
        t_score_vec best;     // running minimum per parent state
        logic       last;
    } t_cell;

    // Saturating add, all ones is infinity.
    function automatic t_score sat_add(input t_score a, input t_score b);
        logic [SCORE_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[SCORE_BITS] ? {SCORE_BITS{1'b1}} : s[SCORE_BITS-1:0];
    endfunction

    function automatic t_score field_to_score(input t_field f);
        logic [31:0] w;
        w = 32'(f);
        return w[SCORE_BITS-1:0];
    endfunction

    function automatic t_field score_to_field(input t_score s);
        logic [31:0] w;
        w = 32'(s);
        return w[FIELD_BITS-1:0];
    endfunction

    // Cost from child state h, taken from one column.
    function automatic t_score cost_entry(input t_cost_col col, input int h);
        logic [31:0] w;
        w = 32'(col[h*COST_BITS +: COST_BITS]);
        return w[SCORE_BITS-1:0];
    endfunction

endpackage

[src/smps_cell.sv]
// smps_cell: one cell of the min-plus chain; folds one child state into all running minima.
// Depends on smps_pkg.
module smps_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  smps_pkg::t_cell    i_data,
    input  smps_pkg::t_score_vec i_cost,   // cost from this cell's child state to each parent
    output logic               o_valid,
    input  logic               i_ready,
    output smps_pkg::t_cell    o_data
);

    logic            r_valid;
    smps_pkg::t_cell r_data;
    smps_pkg::t_cell n_data;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        smps_pkg::t_score t;
        n_data = i_data;
        for (int j = 0; j < smps_pkg::NUM_STATES; j++) begin
            t = smps_pkg::sat_add(i_data.child[0], i_cost[j]);
            n_data.best[j] = (t < i_data.best[j]) ? t : i_data.best[j];
        end
        // shift the child scores so the next cell sees its own at slot 0
        for (int h = 0; h < smps_pkg::NUM_STATES - 1; h++) begin
            n_data.child[h] = i_data.child[h+1];
        end
        n_data.child[smps_pkg::NUM_STATES-1] = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

[src/smps_out.sv]
// smps_out: output stage; adds the partial scores to the minima and holds the result.
// Depends on smps_pkg.
module smps_out (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  smps_pkg::t_cell i_data,
    output logic            o_valid,
    input  logic            i_stall,
    output smps_pkg::t_field o_score [smps_pkg::MAX_ST],
    output logic            o_last
);

    logic             r_valid;
    smps_pkg::t_field r_score [smps_pkg::MAX_ST];
    smps_pkg::t_field n_score [smps_pkg::MAX_ST];
    logic             r_last;

    assign o_ready = !r_valid || !i_stall;

    for (genvar j = 0; j < smps_pkg::MAX_ST; j++) begin : g_sum
        if (j < smps_pkg::NUM_STATES) begin : g_used
            assign n_score[j] = smps_pkg::score_to_field(
                smps_pkg::sat_add(i_data.partial[j], i_data.best[j]));
        end else begin : g_unused
            assign n_score[j] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_score <= n_score;
            r_last  <= i_data.last;
        end
    end

    assign o_valid = r_valid;
    assign o_score = r_score;
    assign o_last  = r_last;

endmodule

[src/sankoff_min_plus_step.sv]
// Sankoff min-plus step: new_j = partial_j + min_h(child_h + cost(h,j)), saturating.
// One register stage per child state, then the output add.
// Throughput one site per cycle while i_stall is low; every stage has its own valid.
// Synchronous active-low reset empties the chain and reloads the default costs
// (0 on the diagonal, 1 elsewhere). Config writes are always ready.
module sankoff_min_plus_step (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input channel
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [15:0]           i_child_score_0,
    input  logic [15:0]           i_child_score_1,
    input  logic [15:0]           i_child_score_2,
    input  logic [15:0]           i_child_score_3,
    input  logic [15:0]           i_partial_score_0,
    input  logic [15:0]           i_partial_score_1,
    input  logic [15:0]           i_partial_score_2,
    input  logic [15:0]           i_partial_score_3,
    input  logic                  i_site_last,
    // result channel
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [15:0]           o_new_score_0,
    output logic [15:0]           o_new_score_1,
    output logic [15:0]           o_new_score_2,
    output logic [15:0]           o_new_score_3,
    output logic                  o_site_last_out,
    // config write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  smps_pkg::t_cfg_idx    i_cfg_index,
    input  smps_pkg::t_cost_col   i_cfg_data
);

    localparam int N = smps_pkg::NUM_STATES;

    // Cost columns, one per parent state.
    smps_pkg::t_cost_col r_cost [smps_pkg::MAX_ST];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cost <= smps_pkg::COST_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                smps_pkg::REG_COST_COL_0: r_cost[0] <= i_cfg_data;
                smps_pkg::REG_COST_COL_1: r_cost[1] <= i_cfg_data;
                smps_pkg::REG_COST_COL_2: r_cost[2] <= i_cfg_data;
                smps_pkg::REG_COST_COL_3: r_cost[3] <= i_cfg_data;
                default: ; // writes beyond the map are dropped
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // Collect the per-state ports into arrays.
    smps_pkg::t_field w_child_in   [smps_pkg::MAX_ST];
    smps_pkg::t_field w_partial_in [smps_pkg::MAX_ST];
    smps_pkg::t_field w_score_out  [smps_pkg::MAX_ST];

    assign w_child_in[0]   = i_child_score_0;
    assign w_child_in[1]   = i_child_score_1;
    assign w_child_in[2]   = i_child_score_2;
    assign w_child_in[3]   = i_child_score_3;
    assign w_partial_in[0] = i_partial_score_0;
    assign w_partial_in[1] = i_partial_score_1;
    assign w_partial_in[2] = i_partial_score_2;
    assign w_partial_in[3] = i_partial_score_3;

    // Chain links: index k feeds cell k; index N feeds the output stage.
    logic            w_valid [N+1];
    logic            w_ready [N+1];
    smps_pkg::t_cell w_data  [N+1];

    // Head of the chain: scores masked to score width, minima start at infinity.
    for (genvar h = 0; h < N; h++) begin : g_head
        assign w_data[0].child[h]   = smps_pkg::field_to_score(w_child_in[h]);
        assign w_data[0].partial[h] = smps_pkg::field_to_score(w_partial_in[h]);
        assign w_data[0].best[h]    = {smps_pkg::SCORE_BITS{1'b1}};
    end
    assign w_data[0].last = i_site_last;
    assign w_valid[0]     = i_valid;
    assign o_stall        = !w_ready[0];

    // Cell k handles child state k against every parent column.
    for (genvar k = 0; k < N; k++) begin : g_cell
        smps_pkg::t_score_vec w_cost_row;
        for (genvar j = 0; j < N; j++) begin : g_row
            assign w_cost_row[j] = smps_pkg::cost_entry(r_cost[j], k);
        end

        smps_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[k]),
            .o_ready (w_ready[k]),
            .i_data  (w_data[k]),
            .i_cost  (w_cost_row),
            .o_valid (w_valid[k+1]),
            .i_ready (w_ready[k+1]),
            .o_data  (w_data[k+1])
        );
    end

    smps_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_valid[N]),
        .o_ready (w_ready[N]),
        .i_data  (w_data[N]),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_score (w_score_out),
        .o_last  (o_site_last_out)
    );

    assign o_new_score_0 = w_score_out[0];
    assign o_new_score_1 = w_score_out[1];
    assign o_new_score_2 = w_score_out[2];
    assign o_new_score_3 = w_score_out[3];

`ifndef SYNTHESIS
    // An idle or draining output never backs up into the input.
    a_no_stall_when_out_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("input stalled while output register empty");

    a_no_stall_when_out_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_stall |-> !o_stall)
        else $error("input stalled while result side is taking");

    // An item in the last cell that cannot move stays put.
    a_last_cell_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_valid[N] && !w_ready[N]) |=> w_valid[N])
        else $error("item lost from last cell under back-pressure");
`endif

endmodule
